// ===== sv/video_register_port_vram_map_defines.svh =====
// Assertion macros used by the register port design.
`ifndef VIDEO_REGISTER_PORT_VRAM_MAP_DEFINES_SVH
`define VIDEO_REGISTER_PORT_VRAM_MAP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VRPVM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vrpvm assertion failed");

// Next-cycle implication, checked outside reset.
`define VRPVM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vrpvm assertion failed");

`endif

// ===== sv/vrpvm_pkg.sv =====
// Package with the operation codes, item types and helpers of the register port.
`timescale 1ns / 1ps
package vrpvm_pkg;

	localparam int QueueDepth = 2;

	localparam logic [2:0] CMD_READ     = 3'd0;
	localparam logic [2:0] CMD_WRITE    = 3'd1;
	localparam logic [2:0] CMD_PEEK     = 3'd2;
	localparam logic [2:0] CMD_VBLANK   = 3'd3;
	localparam logic [2:0] CMD_PRERENDER = 3'd4;

	localparam logic [2:0] REG_CONTROL  = 3'd0;
	localparam logic [2:0] REG_MASK     = 3'd1;
	localparam logic [2:0] REG_STATUS   = 3'd2;
	localparam logic [2:0] REG_OAM_ADDR = 3'd3;
	localparam logic [2:0] REG_OAM_DATA = 3'd4;
	localparam logic [2:0] REG_SCROLL   = 3'd5;
	localparam logic [2:0] REG_ADDR     = 3'd6;
	localparam logic [2:0] REG_DATA     = 3'd7;

	localparam logic [7:0] STATUS_FLAG_MASK = 8'hE0;
	localparam logic [7:0] BUFFER_LOW_MASK  = 8'h1F;
	localparam logic [7:0] PAL_GREY_MASK    = 8'h30;
	localparam logic [7:0] PAL_FULL_MASK    = 8'h3F;
	localparam logic [5:0] PAL_PAGE         = 6'h3F;
	localparam logic [15:0] STEP_ROW        = 16'd32;
	localparam logic [15:0] STEP_ONE        = 16'd1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_RD_STATUS,
		OP_RD_OAM,
		OP_RD_DATA,
		OP_WR_CONTROL,
		OP_WR_MASK,
		OP_WR_OAM_ADDR,
		OP_WR_OAM_DATA,
		OP_WR_SCROLL,
		OP_WR_ADDR,
		OP_WR_DATA,
		OP_PEEK_CONTROL,
		OP_PEEK_MASK,
		OP_PEEK_STATUS,
		OP_VBLANK,
		OP_PRERENDER
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
	} op_item_t;

	function automatic op_kind_t classify(input logic [2:0] cmd, input logic [2:0] idx);
		op_kind_t k;
		k = OP_NONE;
		unique case (cmd)
			CMD_READ: begin
				unique case (idx)
					REG_STATUS:   k = OP_RD_STATUS;
					REG_OAM_DATA: k = OP_RD_OAM;
					REG_DATA:     k = OP_RD_DATA;
					default:      k = OP_NONE;
				endcase
			end
			CMD_WRITE: begin
				unique case (idx)
					REG_CONTROL:  k = OP_WR_CONTROL;
					REG_MASK:     k = OP_WR_MASK;
					REG_OAM_ADDR: k = OP_WR_OAM_ADDR;
					REG_OAM_DATA: k = OP_WR_OAM_DATA;
					REG_SCROLL:   k = OP_WR_SCROLL;
					REG_ADDR:     k = OP_WR_ADDR;
					REG_DATA:     k = OP_WR_DATA;
					default:      k = OP_NONE;
				endcase
			end
			CMD_PEEK: begin
				unique case (idx)
					REG_CONTROL: k = OP_PEEK_CONTROL;
					REG_MASK:    k = OP_PEEK_MASK;
					REG_STATUS:  k = OP_PEEK_STATUS;
					default:     k = OP_NONE;
				endcase
			end
			CMD_VBLANK:    k = OP_VBLANK;
			CMD_PRERENDER: k = OP_PRERENDER;
			default:       k = OP_NONE;
		endcase
		return k;
	endfunction

endpackage

// ===== sv/vrpvm_front.sv =====
// Front end: accepts input items and classifies them into operations.
`timescale 1ns / 1ps
module vrpvm_front
	import vrpvm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] in_command,
	input  logic [2:0] in_reg_index,
	input  logic [7:0] in_write_data,
	output logic       push_valid,
	input  logic       push_ready,
	output op_item_t   push_item
);

	logic     valid_s1;
	op_item_t item_s1;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.kind <= classify(in_command, in_reg_index);
			item_s1.data <= in_write_data;
		end
	end

endmodule

// ===== sv/vrpvm_queue.sv =====
// Two-entry queue of classified operations between front and back.
`timescale 1ns / 1ps
`include "video_register_port_vram_map_defines.svh"
module vrpvm_queue
	import vrpvm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  op_item_t push_item,
	output logic     pop_valid,
	input  logic     pop_ready,
	output op_item_t pop_item
);

	localparam int PtrW = $clog2(QueueDepth);

	op_item_t            slot_q [QueueDepth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [PtrW:0]       count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != (PtrW+1)'(QueueDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	`VRPVM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= (PtrW+1)'(QueueDepth))
	`VRPVM_ASSERT_NEXT(a_push_only, push && !pop, count_q == $past(count_q) + 1'b1)
	`VRPVM_ASSERT_NEXT(a_pop_only, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule

// ===== sv/vrpvm_back.sv =====
// Back end: register state, video memories and the result register.
`timescale 1ns / 1ps
module vrpvm_back
	import vrpvm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mirroring_mode_we,
	input  logic       mirroring_mode_wdata,
	input  logic       op_valid,
	output logic       op_ready,
	input  op_item_t   op_item,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] res_read_data,
	output logic       res_nmi
);

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t     state_q;
	op_item_t   op_q;
	logic       mirror_q;
	logic [7:0] control_q, mask_q, status_q, rbuf_q, oam_addr_q;
	logic       toggle_q;
	logic [15:0] cur_q, temp_q;
	logic [2:0] fine_x_q;
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_nmi_q;

	logic [7:0] sprite_mem  [256];
	logic [7:0] pattern_mem [8192];
	logic [7:0] name_mem    [2048];
	logic [7:0] palette_mem [32];
	logic [7:0] spr_rd_q, pat_rd_q, name_rd_q, pal_rd_q;

	logic [10:0] name_idx;
	logic [4:0]  pal_idx;
	logic        in_pattern, in_palette;
	logic [7:0]  vmem_byte;
	logic [15:0] step;
	logic        exec_go;
	logic [7:0]  rd;
	logic        nmi;
	logic [7:0]  d;

	assign op_ready  = (state_q == ST_IDLE);
	assign exec_go   = (state_q == ST_EXEC) && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res_read_data = out_data_q;
	assign res_nmi   = out_nmi_q;
	assign d         = op_q.data;

	// Video address decode from the low 14 bits of the current address.
	always_comb begin
		name_idx   = {mirror_q ? cur_q[11] : cur_q[10], cur_q[9:0]};
		pal_idx    = (cur_q[4] && cur_q[1:0] == 2'b00) ? {1'b0, cur_q[3:0]} : cur_q[4:0];
		in_pattern = !cur_q[13];
		in_palette = (cur_q[13:8] == PAL_PAGE);
		step       = control_q[2] ? STEP_ROW : STEP_ONE;
		if (in_pattern) begin
			vmem_byte = pat_rd_q;
		end else if (in_palette) begin
			vmem_byte = pal_rd_q & (mask_q[0] ? PAL_GREY_MASK : PAL_FULL_MASK);
		end else begin
			vmem_byte = name_rd_q;
		end
	end

	always_comb begin
		rd  = 8'd0;
		nmi = 1'b0;
		unique case (op_q.kind)
			OP_RD_STATUS:    rd = (status_q & STATUS_FLAG_MASK) | (rbuf_q & BUFFER_LOW_MASK);
			OP_RD_OAM:       rd = spr_rd_q;
			OP_RD_DATA:      rd = in_palette ? vmem_byte : rbuf_q;
			OP_PEEK_CONTROL: rd = control_q;
			OP_PEEK_MASK:    rd = mask_q;
			OP_PEEK_STATUS:  rd = status_q;
			OP_VBLANK:       nmi = control_q[7];
			default: begin
				rd  = 8'd0;
				nmi = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mirror_q    <= 1'b0;
			control_q   <= '0;
			mask_q      <= '0;
			status_q    <= '0;
			rbuf_q      <= '0;
			oam_addr_q  <= '0;
			toggle_q    <= 1'b0;
			cur_q       <= '0;
			temp_q      <= '0;
			fine_x_q    <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_nmi_q   <= 1'b0;
		end else begin
			if (mirroring_mode_we) begin
				mirror_q <= mirroring_mode_wdata;
			end
			if (res_ready && !exec_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (op_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_data_q  <= rd;
						out_nmi_q   <= nmi;
						unique case (op_q.kind)
							OP_RD_STATUS: begin
								status_q[7] <= 1'b0;
								toggle_q    <= 1'b0;
							end
							OP_RD_DATA: begin
								rbuf_q <= vmem_byte;
								cur_q  <= cur_q + step;
							end
							OP_WR_CONTROL: begin
								control_q     <= d;
								temp_q[11:10] <= d[1:0];
							end
							OP_WR_MASK:     mask_q <= d;
							OP_WR_OAM_ADDR: oam_addr_q <= d;
							OP_WR_OAM_DATA: oam_addr_q <= oam_addr_q + 1'b1;
							OP_WR_SCROLL: begin
								if (!toggle_q) begin
									fine_x_q    <= d[2:0];
									temp_q[4:0] <= d[7:3];
								end else begin
									temp_q[14:12] <= d[2:0];
									temp_q[9:5]   <= d[7:3];
								end
								toggle_q <= !toggle_q;
							end
							OP_WR_ADDR: begin
								if (!toggle_q) begin
									temp_q[15:8] <= {2'b00, d[5:0]};
								end else begin
									temp_q[7:0] <= d;
									cur_q       <= {temp_q[15:8], d};
								end
								toggle_q <= !toggle_q;
							end
							OP_WR_DATA:   cur_q <= cur_q + step;
							OP_VBLANK:    status_q[7] <= 1'b1;
							OP_PRERENDER: status_q <= status_q & ~STATUS_FLAG_MASK;
							default:      status_q <= status_q;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && op_valid) begin
			op_q <= op_item;
		end
	end

	// The current and sprite addresses only move in the execute cycle, so the registered reads
	// taken while idle are still valid when the operation runs.
	always_ff @(posedge clk) begin
		spr_rd_q  <= sprite_mem[oam_addr_q];
		pat_rd_q  <= pattern_mem[cur_q[12:0]];
		name_rd_q <= name_mem[name_idx];
		pal_rd_q  <= palette_mem[pal_idx];
		if (exec_go && op_q.kind == OP_WR_OAM_DATA) begin
			sprite_mem[oam_addr_q] <= d;
		end
		if (exec_go && op_q.kind == OP_WR_DATA) begin
			if (in_pattern) begin
				pattern_mem[cur_q[12:0]] <= d;
			end else if (in_palette) begin
				palette_mem[pal_idx] <= d;
			end else begin
				name_mem[name_idx] <= d;
			end
		end
	end

endmodule

// ===== sv/video_register_port_vram_map.sv =====
// Top level of the video register port with its video memory map.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser command, tdata reg_index, write_data
//  m_*       out        m_tvalid / m_tready  tdata read_data, nmi_request
//  mirroring in         mirroring_mode_we    mirroring_mode_wdata
//
// The execute unit takes each item through an idle state, which reads the memories at
// the current address, and an execute state, which updates state and loads the result
// register. An accepted item reaches the execute unit through the classify register
// and the two-entry queue. All control state clears on arst_n; the memories hold
// garbage until written. A stalled output holds the execute unit, while the front
// keeps accepting until the queue is full.
`timescale 1ns / 1ps
module video_register_port_vram_map
	import vrpvm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        mirroring_mode_we,
	input  logic        mirroring_mode_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [2:0] reg_index, [10:3] write_data, rest zero
	input  logic [7:0]  s_tuser,  // [2:0] command, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [7:0] read_data, [8] nmi_request, rest zero
);

	logic     push_valid, push_ready, pop_valid, pop_ready;
	op_item_t push_item, pop_item;
	logic [7:0] read_data;
	logic     nmi_request;

	assign m_tdata = {7'd0, nmi_request, read_data};

	vrpvm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_command    (s_tuser[2:0]),
		.in_reg_index  (s_tdata[2:0]),
		.in_write_data (s_tdata[10:3]),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	vrpvm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	vrpvm_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.mirroring_mode_we    (mirroring_mode_we),
		.mirroring_mode_wdata (mirroring_mode_wdata),
		.op_valid             (pop_valid),
		.op_ready             (pop_ready),
		.op_item              (pop_item),
		.res_valid            (m_tvalid),
		.res_ready            (m_tready),
		.res_read_data        (read_data),
		.res_nmi              (nmi_request)
	);

endmodule
